// ===== src/rmd_pkg.sv =====
package rmd_pkg;

    localparam int FIELD_BITS     = 32;
    localparam int CHAR_BITS      = 8;
    localparam int CFG_INDEX_BITS = 2;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t CFG_EXPONENT = 2'd0;
    localparam cfg_index_t CFG_MODULUS  = 2'd1;

    localparam logic [FIELD_BITS-1:0] EXPONENT_RESET = 32'd1;
    localparam logic [FIELD_BITS-1:0] MODULUS_RESET  = 32'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SQUARE,
        ST_MULT,
        ST_DONE
    } rmd_state_t;

endpackage

// ===== src/rmd_in_if.sv =====
interface rmd_in_if import rmd_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] cipher_value;
    logic                  last_in;

    modport source (output valid, output cipher_value, output last_in, input ready);
    modport sink   (input valid, input cipher_value, input last_in, output ready);
endinterface

// ===== src/rmd_out_if.sv =====
interface rmd_out_if import rmd_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] plain_value;
    logic [CHAR_BITS-1:0]  plain_char;
    logic                  last_out;

    modport source (output valid, output plain_value, output plain_char, output last_out,
                    input ready);
    modport sink   (input valid, input plain_value, input plain_char, input last_out,
                    output ready);
endinterface

// ===== src/rmd_cfg_if.sv =====
interface rmd_cfg_if import rmd_pkg::*;;
    logic                  valid;
    logic                  ready;
    cfg_index_t            index;
    logic [FIELD_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/rsa_modexp_decrypt.sv =====
// Modular exponentiation for RSA decryption: plain = cipher^exponent mod modulus.
// cipher: input words (cipher_value, last_in), valid/ready.
// plain:  result words (plain_value, plain_char, last_out), valid/ready.
// cfg:    register writes, index 0 = exponent, index 1 = modulus; always ready.
//         Write only while no word is in flight.
// One shared modular shift-add unit does one multiplier bit per cycle, on
// operands of WORD_BITS bits (capped at 32 bits). Per word: an accept step,
// input reduction of the cipher word, then per exponent bit a square and,
// for a one bit, a multiply, then a step to load the output. A modulus of
// 0 or 1 skips the arithmetic.
// cipher.ready is high only when the unit is idle. A finished word sits in the
// output register; the next word is accepted while it waits. If the output
// register is still full when another result is ready, the unit holds it until
// plain.ready frees the register.
// Reset clears the output valid, returns the unit to idle and sets exponent 1,
// modulus 2.
module rsa_modexp_decrypt import rmd_pkg::*; #(
    parameter int WORD_BITS   = 32,
    parameter int CHAR_OFFSET = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    rmd_in_if.sink    cipher,
    rmd_out_if.source plain,
    rmd_cfg_if.sink   cfg
);

    localparam int DW = (WORD_BITS < FIELD_BITS) ? WORD_BITS : FIELD_BITS;
    localparam int CW = $clog2(DW);
    localparam logic [CW-1:0] CNT_TOP = CW'(DW - 1);

    rmd_state_t state_reg, state_next;

    logic [DW-1:0] exponent_reg;
    logic [DW-1:0] modulus_reg;
    logic [DW-1:0] cipher_reg, cipher_next;
    logic [DW-1:0] base_reg, base_next;
    logic [DW-1:0] r_reg, r_next;
    logic [DW-1:0] acc_reg, acc_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] ecnt_reg, ecnt_next;
    logic          last_reg, last_next;

    logic          out_valid_reg, out_valid_next;
    logic [DW-1:0] out_value_reg, out_value_next;
    logic          out_last_reg, out_last_next;

    logic [DW-1:0] step_addend;
    logic          step_bit;
    logic [DW-1:0] step_res;
    logic          in_fire;
    logic          mod_small;

    // acc*2 mod m, then + addend mod m when bit is set; acc, addend < m
    function automatic logic [DW-1:0] mod_step(
        input logic [DW-1:0] acc,
        input logic [DW-1:0] addend,
        input logic          bit_in,
        input logic [DW-1:0] m
    );
        logic [DW:0]   dbl;
        logic [DW:0]   sum;
        logic [DW-1:0] d;
        dbl = {acc, 1'b0};
        if (dbl >= {1'b0, m})
            dbl = dbl - {1'b0, m};
        d = dbl[DW-1:0];
        sum = {1'b0, d} + {1'b0, addend};
        if (sum >= {1'b0, m})
            sum = sum - {1'b0, m};
        return bit_in ? sum[DW-1:0] : d;
    endfunction

    assign in_fire   = cipher.valid && cipher.ready;
    assign mod_small = (modulus_reg >> 1) == '0;

    assign cipher.ready = (state_reg == ST_IDLE);
    assign cfg.ready    = 1'b1;

    assign plain.valid       = out_valid_reg;
    assign plain.plain_value = FIELD_BITS'(out_value_reg);
    assign plain.plain_char  = out_value_reg[CHAR_BITS-1:0] + CHAR_BITS'(CHAR_OFFSET);
    assign plain.last_out    = out_last_reg;

    always_comb
    begin
        case (state_reg)
            ST_REDUCE:
            begin
                step_addend = DW'(1);
                step_bit    = cipher_reg[cnt_reg];
            end
            ST_SQUARE:
            begin
                step_addend = r_reg;
                step_bit    = r_reg[cnt_reg];
            end
            ST_MULT:
            begin
                step_addend = r_reg;
                step_bit    = base_reg[cnt_reg];
            end
            default:
            begin
                step_addend = r_reg;
                step_bit    = 1'b0;
            end
        endcase
        step_res = mod_step(acc_reg, step_addend, step_bit, modulus_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        cipher_next    = cipher_reg;
        base_next      = base_reg;
        r_next         = r_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        ecnt_next      = ecnt_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;

        if (plain.valid && plain.ready)
            out_valid_next = 1'b0;

        unique case (state_reg) inside
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cipher_next = cipher.cipher_value[DW-1:0];
                    last_next   = cipher.last_in;
                    acc_next    = '0;
                    cnt_next    = CNT_TOP;
                    if (mod_small)
                    begin
                        r_next     = '0;
                        state_next = ST_DONE;
                    end
                    else
                        state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                acc_next = step_res;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    base_next  = step_res;
                    r_next     = DW'(1);
                    acc_next   = '0;
                    cnt_next   = CNT_TOP;
                    ecnt_next  = CNT_TOP;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE, ST_MULT:
            begin
                acc_next = step_res;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    r_next   = step_res;
                    acc_next = '0;
                    cnt_next = CNT_TOP;
                    if (state_reg == ST_SQUARE && exponent_reg[ecnt_reg])
                        state_next = ST_MULT;
                    else if (ecnt_reg == '0)
                        state_next = ST_DONE;
                    else
                    begin
                        ecnt_next  = ecnt_reg - 1'b1;
                        state_next = ST_SQUARE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || plain.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = r_reg;
                    out_last_next  = last_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg <= EXPONENT_RESET[DW-1:0];
            modulus_reg  <= MODULUS_RESET[DW-1:0];
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_EXPONENT: exponent_reg <= cfg.data[DW-1:0];
                CFG_MODULUS:  modulus_reg  <= cfg.data[DW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        cipher_reg    <= cipher_next;
        base_reg      <= base_next;
        r_reg         <= r_next;
        acc_reg       <= acc_next;
        cnt_reg       <= cnt_next;
        ecnt_reg      <= ecnt_next;
        last_reg      <= last_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

`ifndef SYNTHESIS
    // an accepted word never completes in the same pass through idle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !cipher.ready)
        else $error("input ready right after accept");

    // running product, partial sum and base stay reduced
    a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQUARE || state_reg == ST_MULT)
            |-> (r_reg < modulus_reg && acc_reg < modulus_reg && base_reg < modulus_reg))
        else $error("operand not reduced modulo modulus");

    // end of input reduction starts the first square with r = 1
    a_reduce_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REDUCE && cnt_reg == '0)
            |=> (state_reg == ST_SQUARE && r_reg == DW'(1) && ecnt_reg == CNT_TOP))
        else $error("bad transition out of reduction");

    // a held result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (plain.valid && !plain.ready) |=> $stable(out_value_reg))
        else $error("pending result overwritten");
`endif

endmodule
